// File: hw/rtl/kmna_pkg.sv
// kmna_pkg: types and constants shared by the nearest-centroid assign block
// no dependencies
package kmna_pkg;

    localparam int COORD_W = 16;
    localparam int DIST_W  = 34;
    localparam int CNT_W   = 11;
    localparam int SUM_W   = 26;
    localparam int SSE_W   = 44;
    localparam int PIDX_W  = 10;
    localparam int CL_W    = 3;
    localparam int NDIM    = 4;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_WRITE  = 2'd1,
        FUNC_ASSIGN = 2'd2,
        FUNC_READ   = 2'd3
    } func_t;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        func_t               func;
        logic [PIDX_W-1:0]   point_index;
        logic [CL_W-1:0]     cluster;
        coord_t [NDIM-1:0]   coord;
    } item_t;

endpackage

// File: hw/rtl/kmna_ram.sv
// kmna_ram: generic simple dual-port RAM, one write and one read port, registered read
// no dependencies
module kmna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hw/rtl/kmna_front.sv
// kmna_front: input stage and two-entry queue toward the execution engine
// depends on kmna_pkg
module kmna_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  kmna_pkg::item_t in_item,
    output logic           q_valid,
    input  logic           q_ready,
    output kmna_pkg::item_t q_item
);
    kmna_pkg::item_t buf_reg [2];
    logic [1:0] cnt_reg;
    logic       rd_reg, wr_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = buf_reg[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_reg] <= in_item;
        end
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end else begin
            if (push) wr_reg <= ~wr_reg;
            if (pop)  rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// File: hw/rtl/kmna_back.sv
// kmna_back: sequencer that carries out one item, nearest-centroid search and totals
// depends on kmna_pkg, kmna_ram
module kmna_back #(
    parameter int CLUSTERS = 8,
    parameter int DIMS     = 4,
    parameter int POINTS   = 1024
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  kmna_pkg::item_t q_item,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [2:0]      m_assigned_cluster,
    output logic [33:0]     m_min_distance,
    output logic            m_moved,
    output logic [10:0]     m_member_count,
    output logic signed [25:0] m_sum0,
    output logic signed [25:0] m_sum1,
    output logic signed [25:0] m_sum2,
    output logic signed [25:0] m_sum3,
    output logic [43:0]     m_total_sse,
    output logic [10:0]     m_moved_total
);
    localparam int KW = $clog2(CLUSTERS);
    localparam int PW = (POINTS > 1) ? $clog2(POINTS) : 1;
    localparam int NW = $clog2(CLUSTERS + 1);
    localparam logic [kmna_pkg::CNT_W-1:0] CNT_MAX = '1;
    localparam logic [kmna_pkg::SSE_W-1:0] SSE_MAX = '1;
    localparam logic signed [kmna_pkg::SUM_W-1:0] SUM_MAX = {1'b0, {(kmna_pkg::SUM_W-1){1'b1}}};
    localparam logic signed [kmna_pkg::SUM_W-1:0] SUM_MIN = {1'b1, {(kmna_pkg::SUM_W-1){1'b0}}};

    typedef enum logic [2:0] {S_CLR, S_IDLE, S_SCAN, S_ACC, S_UPD, S_OUT} state_t;

    state_t state_reg;
    kmna_pkg::item_t it_reg;
    kmna_pkg::coord_t [kmna_pkg::NDIM-1:0] cent_reg [CLUSTERS];
    logic [kmna_pkg::CNT_W-1:0] cnt_reg [CLUSTERS];
    logic signed [kmna_pkg::SUM_W-1:0] sum_reg [CLUSTERS][kmna_pkg::NDIM];
    logic [kmna_pkg::SSE_W-1:0] sse_reg;
    logic [kmna_pkg::CNT_W-1:0] mvc_reg;
    logic [NW-1:0] k_reg;
    logic [KW-1:0] best_reg;
    logic [kmna_pkg::DIST_W-1:0] bestd_reg;
    logic [kmna_pkg::DIST_W-1:0] dist_reg;
    logic [KW-1:0] dk_reg;
    logic dvalid_reg;
    logic [PW-1:0] clr_reg;
    logic clr_we;
    logic pidx_ok;
    logic [PW-1:0] paddr;
    logic [PW-1:0] ram_waddr;
    logic [KW-1:0] ram_wdata;
    logic [KW-1:0] prdata;
    logic pwe;
    logic [kmna_pkg::DIST_W-1:0] dist_next;
    logic [KW-1:0] kidx;
    logic [kmna_pkg::SSE_W:0] sse_sum;

    assign pidx_ok = ({{(16-kmna_pkg::PIDX_W){1'b0}}, it_reg.point_index} < 16'(POINTS));
    assign paddr   = PW'(it_reg.point_index);
    assign pwe     = (state_reg == S_UPD) && (it_reg.func == kmna_pkg::FUNC_ASSIGN) && pidx_ok;
    assign kidx    = KW'(k_reg);

    // clearing pass after reset zeroes the stored point clusters
    assign clr_we    = (state_reg == S_CLR);
    assign ram_waddr = clr_we ? clr_reg : paddr;
    assign ram_wdata = clr_we ? '0 : best_reg;

    kmna_ram #(.WIDTH(KW), .DEPTH(POINTS > 1 ? POINTS : 2)) u_pc (
        .aclk(aclk), .we(pwe || clr_we), .waddr(ram_waddr),
        .wdata(ram_wdata), .raddr(paddr), .rdata(prdata)
    );

    always_comb begin
        logic signed [16:0] t;
        logic [33:0] a;
        dist_next = '0;
        for (int d = 0; d < kmna_pkg::NDIM; d++) begin
            if (d < DIMS) begin
                t = 17'(it_reg.coord[d]) - 17'(cent_reg[kidx][d]);
                a = 34'(t < 0 ? -t : t);
                dist_next = dist_next + 34'(a * a);
            end
        end
    end

    assign q_ready = (state_reg == S_IDLE);
    assign sse_sum = {1'b0, sse_reg} + 45'(bestd_reg);

    always_ff @(posedge aclk) begin
        logic signed [kmna_pkg::SUM_W:0] s;
        logic mv;
        if (!aresetn) begin
            state_reg  <= S_CLR;
            clr_reg    <= '0;
            m_valid    <= 1'b0;
            sse_reg    <= '0;
            mvc_reg    <= '0;
            dvalid_reg <= 1'b0;
            for (int c = 0; c < CLUSTERS; c++) begin
                cnt_reg[c]  <= '0;
                cent_reg[c] <= '0;
                for (int d = 0; d < kmna_pkg::NDIM; d++) sum_reg[c][d] <= '0;
            end
        end else begin
            unique case (state_reg)
                S_CLR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == PW'(POINTS - 1)) state_reg <= S_IDLE;
                end
                S_IDLE: begin
                    if (q_valid) begin
                        it_reg     <= q_item;
                        k_reg      <= '0;
                        dvalid_reg <= 1'b0;
                        state_reg  <= (q_item.func == kmna_pkg::FUNC_ASSIGN) ? S_SCAN : S_UPD;
                    end
                end
                S_SCAN: begin
                    dist_reg   <= dist_next;
                    dk_reg     <= kidx;
                    dvalid_reg <= 1'b1;
                    if (dvalid_reg && (dk_reg == '0 || dist_reg < bestd_reg)) begin
                        bestd_reg <= dist_reg;
                        best_reg  <= dk_reg;
                    end
                    if (k_reg == NW'(CLUSTERS - 1)) state_reg <= S_ACC;
                    else k_reg <= k_reg + 1'b1;
                end
                S_ACC: begin
                    if (dist_reg < bestd_reg) begin
                        bestd_reg <= dist_reg;
                        best_reg  <= dk_reg;
                    end
                    state_reg <= S_UPD;
                end
                S_UPD: begin
                    m_assigned_cluster <= '0;
                    m_min_distance     <= '0;
                    m_moved            <= 1'b0;
                    m_member_count     <= '0;
                    m_sum0 <= '0; m_sum1 <= '0; m_sum2 <= '0; m_sum3 <= '0;
                    m_total_sse   <= sse_reg;
                    m_moved_total <= mvc_reg;
                    unique case (it_reg.func)
                        kmna_pkg::FUNC_CLEAR: begin
                            sse_reg <= '0;
                            mvc_reg <= '0;
                            m_total_sse   <= '0;
                            m_moved_total <= '0;
                            for (int c = 0; c < CLUSTERS; c++) begin
                                cnt_reg[c] <= '0;
                                for (int d = 0; d < kmna_pkg::NDIM; d++) sum_reg[c][d] <= '0;
                            end
                        end
                        kmna_pkg::FUNC_WRITE: begin
                            if ({1'b0, it_reg.cluster} < 5'(CLUSTERS)) begin
                                for (int d = 0; d < kmna_pkg::NDIM; d++)
                                    cent_reg[KW'(it_reg.cluster)][d] <=
                                        (d < DIMS) ? it_reg.coord[d] : '0;
                            end
                        end
                        kmna_pkg::FUNC_ASSIGN: begin
                            mv = pidx_ok && (prdata != best_reg);
                            if (mv && mvc_reg != CNT_MAX) begin
                                mvc_reg <= mvc_reg + 1'b1;
                                m_moved_total <= mvc_reg + 1'b1;
                            end
                            if (cnt_reg[best_reg] != CNT_MAX)
                                cnt_reg[best_reg] <= cnt_reg[best_reg] + 1'b1;
                            if (sse_sum[kmna_pkg::SSE_W]) begin
                                sse_reg <= SSE_MAX; m_total_sse <= SSE_MAX;
                            end else begin
                                sse_reg <= sse_sum[kmna_pkg::SSE_W-1:0];
                                m_total_sse <= sse_sum[kmna_pkg::SSE_W-1:0];
                            end
                            for (int d = 0; d < kmna_pkg::NDIM; d++) begin
                                if (d < DIMS) begin
                                    s = 27'(sum_reg[best_reg][d]) + 27'(it_reg.coord[d]);
                                    if (s > 27'(SUM_MAX)) sum_reg[best_reg][d] <= SUM_MAX;
                                    else if (s < 27'(SUM_MIN)) sum_reg[best_reg][d] <= SUM_MIN;
                                    else sum_reg[best_reg][d] <= s[kmna_pkg::SUM_W-1:0];
                                end
                            end
                            m_assigned_cluster <= 3'(best_reg);
                            m_min_distance     <= bestd_reg;
                            m_moved            <= mv;
                        end
                        kmna_pkg::FUNC_READ: begin
                            if ({1'b0, it_reg.cluster} < 5'(CLUSTERS)) begin
                                m_member_count <= cnt_reg[KW'(it_reg.cluster)];
                                m_sum0 <= sum_reg[KW'(it_reg.cluster)][0];
                                m_sum1 <= sum_reg[KW'(it_reg.cluster)][1];
                                m_sum2 <= sum_reg[KW'(it_reg.cluster)][2];
                                m_sum3 <= sum_reg[KW'(it_reg.cluster)][3];
                            end
                        end
                    endcase
                    m_valid   <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (m_ready) begin
                        m_valid   <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// File: hw/rtl/kmeans_nearest_centroid_assign.sv
// kmeans_nearest_centroid_assign: top level of the k-means assignment step
// depends on kmna_pkg, kmna_front, kmna_back
//
// input channel s_*: one item per transfer (func, point_index, cluster, coords)
//   clear totals, write a centroid row, assign a point, read one cluster's totals
// result channel m_*: exactly one result per item, in order
// a two-entry queue in front lets the input take items while the engine works
// with an idle engine, clear, write and read go from the queue through S_IDLE and S_UPD,
//   which raises m_valid; assign first passes S_SCAN, one centroid distance per cycle
//   in the shared distance unit over all CLUSTERS centroids, and then S_ACC
// the engine holds one item at a time and takes the next only back in S_IDLE, after S_OUT
// a stalled receiver holds the result; the queue then fills and s_ready drops
// reset clears centroids and totals at once, then a clearing pass over all POINTS entries
//   (1024 by default) zeroes the stored point clusters; items wait in the queue
module kmeans_nearest_centroid_assign #(
    parameter int CLUSTERS = 8,
    parameter int DIMS     = 4,
    parameter int POINTS   = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [9:0]         s_point_index,
    input  logic [2:0]         s_cluster,
    input  logic signed [15:0] s_coord0,
    input  logic signed [15:0] s_coord1,
    input  logic signed [15:0] s_coord2,
    input  logic signed [15:0] s_coord3,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_assigned_cluster,
    output logic [33:0]        m_min_distance,
    output logic               m_moved,
    output logic [10:0]        m_member_count,
    output logic signed [25:0] m_sum0,
    output logic signed [25:0] m_sum1,
    output logic signed [25:0] m_sum2,
    output logic signed [25:0] m_sum3,
    output logic [43:0]        m_total_sse,
    output logic [10:0]        m_moved_total
);
    kmna_pkg::item_t in_item, q_item;
    logic q_valid, q_ready;

    always_comb begin
        in_item.func        = kmna_pkg::func_t'(s_func);
        in_item.point_index = s_point_index;
        in_item.cluster     = s_cluster;
        in_item.coord[0]    = s_coord0;
        in_item.coord[1]    = s_coord1;
        in_item.coord[2]    = s_coord2;
        in_item.coord[3]    = s_coord3;
    end

    kmna_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_valid), .in_ready(s_ready),
        .in_item(in_item), .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    kmna_back #(.CLUSTERS(CLUSTERS), .DIMS(DIMS), .POINTS(POINTS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .q_valid(q_valid), .q_ready(q_ready),
        .q_item(q_item), .m_valid(m_valid), .m_ready(m_ready),
        .m_assigned_cluster(m_assigned_cluster), .m_min_distance(m_min_distance),
        .m_moved(m_moved), .m_member_count(m_member_count),
        .m_sum0(m_sum0), .m_sum1(m_sum1), .m_sum2(m_sum2), .m_sum3(m_sum3),
        .m_total_sse(m_total_sse), .m_moved_total(m_moved_total)
    );
endmodule

// File: hw/rtl/kmna_checker.sv
// kmna_checker: port-level assertions for the assign block, bound to the top level
// depends on kmeans_nearest_centroid_assign ports only
module kmna_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  s_func,
    input logic [2:0]  m_assigned_cluster,
    input logic [33:0] m_min_distance,
    input logic        m_moved,
    input logic [43:0] m_total_sse
);
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_total_sse)
            && $stable(m_min_distance) && $stable(m_assigned_cluster) && $stable(m_moved))
        else $error("result dropped while stalled");
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");
    a_sse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_moved |-> m_total_sse >= 44'(m_min_distance))
        else $error("sse below reported distance");
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_func))
        else $error("input dropped while stalled");
endmodule

bind kmeans_nearest_centroid_assign kmna_checker u_kmna_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .s_func(s_func),
    .m_assigned_cluster(m_assigned_cluster), .m_min_distance(m_min_distance),
    .m_moved(m_moved), .m_total_sse(m_total_sse)
);

// File: sim/kmna_checker.sv
// kmna_scoreboard: watches both channels of the nearest-centroid assign block,
// predicts each result from its own copy of the tables and compares field by field
// depends on kmna_pkg
module kmna_scoreboard (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [9:0]         s_point_index,
    input  logic [2:0]         s_cluster,
    input  logic signed [15:0] s_coord0,
    input  logic signed [15:0] s_coord1,
    input  logic signed [15:0] s_coord2,
    input  logic signed [15:0] s_coord3,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [2:0]         m_assigned_cluster,
    input  logic [33:0]        m_min_distance,
    input  logic               m_moved,
    input  logic [10:0]        m_member_count,
    input  logic signed [25:0] m_sum0,
    input  logic signed [25:0] m_sum1,
    input  logic signed [25:0] m_sum2,
    input  logic signed [25:0] m_sum3,
    input  logic [43:0]        m_total_sse,
    input  logic [10:0]        m_moved_total,
    output int                 fail_count,
    output int                 pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCL = 8;
    localparam int NPTS = 1024;
    localparam logic [10:0] CNT_SAT = 11'd2047;
    localparam logic [43:0] SSE_SAT = {44{1'b1}};

    typedef struct {
        logic [2:0]  cl;
        logic [33:0] min_dist;
        logic        moved;
        logic [10:0] count;
        logic signed [25:0] sum [4];
        logic [43:0] sse;
        logic [10:0] moved_tot;
    } cluster_result_t;

    logic signed [15:0] centroid [NCL][4];
    logic [2:0]         point_home [NPTS];
    logic [10:0]        members [NCL];
    logic signed [25:0] coord_sum [NCL][4];
    logic [43:0]        sse_acc;
    logic [10:0]        moved_acc;
    cluster_result_t    expected_results [$];

    assign pending_count = expected_results.size();

    function automatic cluster_result_t assign_step(logic [1:0] fn, logic [9:0] pidx,
            logic [2:0] cl, logic signed [15:0] c [4]);
        cluster_result_t r;
        logic [33:0] best_d, dk;
        logic [2:0] best;
        logic signed [16:0] diff;
        logic signed [26:0] s;
        r = '{default: '0};
        r.sum = '{default: '0};
        case (kmna_pkg::func_t'(fn))
            kmna_pkg::FUNC_CLEAR: begin
                members = '{default: '0};
                coord_sum = '{default: '{default: '0}};
                sse_acc = '0;
                moved_acc = '0;
            end
            kmna_pkg::FUNC_WRITE: begin
                for (int d = 0; d < 4; d++) centroid[cl][d] = c[d];
            end
            kmna_pkg::FUNC_ASSIGN: begin
                best = 0;
                best_d = '1;
                for (int k = 0; k < NCL; k++) begin
                    dk = 0;
                    for (int d = 0; d < 4; d++) begin
                        diff = 17'(c[d]) - 17'(centroid[k][d]);
                        dk += 34'(diff) * 34'(diff);
                    end
                    if (k == 0 || dk < best_d) begin
                        best_d = dk;
                        best = 3'(k);
                    end
                end
                r.moved = point_home[pidx] != best;
                point_home[pidx] = best;
                if (r.moved && moved_acc != CNT_SAT) moved_acc++;
                if (members[best] != CNT_SAT) members[best]++;
                sse_acc = (SSE_SAT - sse_acc < 44'(best_d)) ? SSE_SAT : sse_acc + 44'(best_d);
                for (int d = 0; d < 4; d++) begin
                    s = 27'(coord_sum[best][d]) + 27'(c[d]);
                    if (s > 27'sd33554431) s = 27'sd33554431;
                    if (s < -27'sd33554432) s = -27'sd33554432;
                    coord_sum[best][d] = 26'(s);
                end
                r.cl = best;
                r.min_dist = best_d;
            end
            default: begin
                r.count = members[cl];
                for (int d = 0; d < 4; d++) r.sum[d] = coord_sum[cl][d];
            end
        endcase
        r.sse = sse_acc;
        r.moved_tot = moved_acc;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge aclk) begin
        cluster_result_t e;
        logic signed [15:0] c [4];
        logic signed [25:0] got_sum [4];
        if (!aresetn) begin
            centroid = '{default: '{default: '0}};
            point_home = '{default: '0};
            members = '{default: '0};
            coord_sum = '{default: '{default: '0}};
            sse_acc = '0;
            moved_acc = '0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transfer", 0, 0);
                end else begin
                    e = expected_results.pop_front();
                    got_sum = '{m_sum0, m_sum1, m_sum2, m_sum3};
                    if (m_assigned_cluster !== e.cl)
                        report_mismatch("assigned_cluster", m_assigned_cluster, e.cl);
                    if (m_min_distance !== e.min_dist)
                        report_mismatch("min_distance", m_min_distance, e.min_dist);
                    if (m_moved !== e.moved) report_mismatch("moved", m_moved, e.moved);
                    if (m_member_count !== e.count)
                        report_mismatch("member_count", m_member_count, e.count);
                    for (int d = 0; d < 4; d++)
                        if (got_sum[d] !== e.sum[d])
                            report_mismatch($sformatf("sum%0d", d), 64'(got_sum[d]),
                                64'(e.sum[d]));
                    if (m_total_sse !== e.sse) report_mismatch("total_sse", m_total_sse, e.sse);
                    if (m_moved_total !== e.moved_tot)
                        report_mismatch("moved_total", m_moved_total, e.moved_tot);
                end
            end
            if (s_valid && s_ready) begin
                c = '{s_coord0, s_coord1, s_coord2, s_coord3};
                expected_results.push_back(assign_step(s_func, s_point_index, s_cluster, c));
            end
        end
    end
endmodule

// File: sim/tb_kmeans_nearest_centroid_assign.sv
// tb_kmeans_nearest_centroid_assign: stimulus and verdict for the assign block
// depends on kmna_pkg, kmna_scoreboard and the block's rtl
module tb_kmeans_nearest_centroid_assign;
    timeunit 1ns;
    timeprecision 1ps;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0, s_ready;
    logic [1:0] s_func = kmna_pkg::FUNC_CLEAR;
    logic [9:0] s_point_index = 0;
    logic [2:0] s_cluster = 0;
    logic signed [15:0] s_coord0 = 0, s_coord1 = 0, s_coord2 = 0, s_coord3 = 0;
    logic m_valid, m_ready = 0;
    logic [2:0] m_assigned_cluster;
    logic [33:0] m_min_distance;
    logic m_moved;
    logic [10:0] m_member_count, m_moved_total;
    logic signed [25:0] m_sum0, m_sum1, m_sum2, m_sum3;
    logic [43:0] m_total_sse;
    int fail_count, pending_count;
    int send_idle = 0, recv_stall = 0;
    int hold_off = 0;
    int cycle_count = 0;

    always #5 aclk = ~aclk;

    kmeans_nearest_centroid_assign DUT (.*);
    kmna_scoreboard u_checker (.*);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver stalls at random, or holds off for a long stretch
    always @(posedge aclk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_ready <= 0;
        end else begin
            m_ready <= $urandom_range(99) >= recv_stall;
        end
    end

    task automatic send_item(kmna_pkg::func_t fn, logic [9:0] pidx, logic [2:0] cl,
            logic signed [15:0] c0, c1, c2, c3);
        while ($urandom_range(99) < send_idle) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_func <= fn;
        s_point_index <= pidx;
        s_cluster <= cl;
        s_coord0 <= c0;
        s_coord1 <= c1;
        s_coord2 <= c2;
        s_coord3 <= c3;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic signed [15:0] rand_coord(bit narrow);
        case ($urandom_range(9))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            default: return narrow ? 16'($signed($urandom_range(200)) - 100) : 16'($urandom);
        endcase
    endfunction

    task automatic random_item();
        int pick;
        bit narrow;
        pick = $urandom_range(99);
        narrow = $urandom_range(1);
        if (pick < 3)
            send_item(kmna_pkg::FUNC_CLEAR, 10'($urandom), 3'($urandom), rand_coord(0),
                rand_coord(0), rand_coord(0), rand_coord(0));
        else if (pick < 18)
            send_item(kmna_pkg::FUNC_WRITE, 10'($urandom), 3'($urandom), rand_coord(narrow),
                rand_coord(narrow), rand_coord(narrow), rand_coord(narrow));
        else if (pick < 80)
            send_item(kmna_pkg::FUNC_ASSIGN,
                $urandom_range(1) ? 10'($urandom_range(15)) : 10'($urandom),
                3'($urandom), rand_coord(narrow), rand_coord(narrow), rand_coord(narrow),
                rand_coord(narrow));
        else
            send_item(kmna_pkg::FUNC_READ, 10'($urandom), 3'($urandom), rand_coord(0),
                rand_coord(0), rand_coord(0), rand_coord(0));
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // directed: reads of empty totals, extreme centroids, ties and a long run into one cluster
        send_item(kmna_pkg::FUNC_READ, 0, 7, 0, 0, 0, 0);
        send_item(kmna_pkg::FUNC_ASSIGN, 10'h3ff, 0, 0, 0, 0, 0);
        send_item(kmna_pkg::FUNC_WRITE, 0, 1, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_item(kmna_pkg::FUNC_WRITE, 0, 7, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_item(kmna_pkg::FUNC_ASSIGN, 5, 0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_item(kmna_pkg::FUNC_ASSIGN, 5, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_item(kmna_pkg::FUNC_ASSIGN, 6, 0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_item(kmna_pkg::FUNC_WRITE, 0, 2, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_item(kmna_pkg::FUNC_ASSIGN, 10'h2aa, 0, 16'sh7fff, 16'sh7fff, 16'sh7fff,
            16'sh7fff);
        send_item(kmna_pkg::FUNC_WRITE, 0, 3, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
        send_item(kmna_pkg::FUNC_ASSIGN, 10'h155, 0, 16'sh7fff, 16'sh8000, 16'sh7fff,
            16'sh8000);
        send_item(kmna_pkg::FUNC_READ, 0, 7, 0, 0, 0, 0);
        send_item(kmna_pkg::FUNC_READ, 0, 1, 0, 0, 0, 0);
        send_item(kmna_pkg::FUNC_READ, 0, 3, 0, 0, 0, 0);
        repeat (60)
            send_item(kmna_pkg::FUNC_ASSIGN, 10'($urandom), 0, 16'sh7fff, 16'sh7fff,
                16'sh7fff, 16'sh7fff);
        send_item(kmna_pkg::FUNC_READ, 0, 1, 0, 0, 0, 0);
        send_item(kmna_pkg::FUNC_READ, 0, 2, 0, 0, 0, 0);
        send_item(kmna_pkg::FUNC_CLEAR, 10'h3ff, 7, -1, -1, -1, -1);
        send_item(kmna_pkg::FUNC_READ, 0, 1, 0, 0, 0, 0);
        // random phases with different idling
        for (int phase = 0; phase < 5; phase++) begin
            send_idle = (phase == 1 || phase == 3) ? 74 : (phase == 4 ? 7 : 0);
            recv_stall = (phase == 2 || phase == 3) ? 74 : (phase == 4 ? 7 : 0);
            if (phase == 2) hold_off = 300;
            repeat (115) random_item();
            if (phase == 3) begin
                s_valid <= 0;
                @(posedge aclk);
                while (pending_count != 0) @(posedge aclk);
            end
        end
        s_valid <= 0;
        send_idle = 0;
        recv_stall = 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
